>>> src/seghist_pkg.sv
// Shared types and constants for the segmentation pixel histogram.
package seghist_pkg;

    localparam int OUT_BITS     = 16;
    localparam int OUT_SLOTS    = 7;
    localparam int MAP_SLOTS    = 16;
    localparam int SLOT_BITS    = 3;
    localparam int MAP_BITS     = MAP_SLOTS * SLOT_BITS;
    localparam int ENTRIES_BITS = 5;
    localparam int ID_BITS      = 24;

    localparam logic [SLOT_BITS-1:0] BLOCK_NONE = 3'd7;

    // Configuration register indexes
    localparam logic REG_MAP     = 1'b0;
    localparam logic REG_ENTRIES = 1'b1;

    localparam logic [MAP_BITS-1:0]     MAP_RESET     = '1;
    localparam logic [ENTRIES_BITS-1:0] ENTRIES_RESET = '0;

    typedef logic [MAP_SLOTS-1:0][SLOT_BITS-1:0] map_t;
    typedef logic [OUT_SLOTS-1:0][OUT_BITS-1:0] counts_t;

    // One pixel request as it travels down the row of counter cells
    typedef struct packed {
        logic                 valid;
        logic                 hit;
        logic [SLOT_BITS-1:0] block;
        logic                 frame_end;
        counts_t              counts;
    } token_t;

endpackage

>>> src/seghist_decode.sv
// Pixel decode: color to segment id to block number.
module seghist_decode #(
    parameter int MAP_ENTRIES = 16,
    parameter int BLOCKS      = 7
) (
    input  logic                                   valid,
    input  logic [7:0]                             red,
    input  logic [7:0]                             green,
    input  logic [7:0]                             blue,
    input  logic                                   frame_end,
    input  logic [seghist_pkg::MAP_BITS-1:0]       segment_block_map,
    input  logic [seghist_pkg::ENTRIES_BITS-1:0]   segment_entries,
    output seghist_pkg::token_t                    token
);

    localparam logic [seghist_pkg::ENTRIES_BITS-1:0] ENTRIES_MAX =
        seghist_pkg::ENTRIES_BITS'(MAP_ENTRIES);
    localparam logic [seghist_pkg::SLOT_BITS-1:0] BLOCK_LIMIT =
        seghist_pkg::SLOT_BITS'(BLOCKS);

    logic [seghist_pkg::ID_BITS-1:0]      encoded;
    logic [seghist_pkg::ID_BITS-1:0]      segid;
    logic [seghist_pkg::ENTRIES_BITS-1:0] limit;
    logic                                 in_table;
    seghist_pkg::map_t                    map;
    logic [seghist_pkg::SLOT_BITS-1:0]    block;

    assign encoded = {blue, green, red};
    assign segid   = encoded - seghist_pkg::ID_BITS'(1);
    assign limit   = (segment_entries > ENTRIES_MAX) ? ENTRIES_MAX : segment_entries;
    assign map     = seghist_pkg::map_t'(segment_block_map);

    // Background pixel decodes to all zero and never passes the table check
    assign in_table = (|encoded) &&
        (segid < {{(seghist_pkg::ID_BITS-seghist_pkg::ENTRIES_BITS){1'b0}}, limit});
    assign block    = map[segid[3:0]];

    always_comb
    begin
        token           = '0;
        token.valid     = valid;
        token.frame_end = frame_end;
        token.block     = block;
        token.hit       = in_table && (block < BLOCK_LIMIT) &&
                          (block != seghist_pkg::BLOCK_NONE);
    end

endmodule

>>> src/seghist_cell.sv
// One block counter cell: counts its own block and hands the request on.
module seghist_cell #(
    parameter int INDEX      = 0,
    parameter int COUNT_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  seghist_pkg::token_t token_in,
    output seghist_pkg::token_t token_out
);

    localparam int OB = seghist_pkg::OUT_BITS;

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] count_inc;
    logic [OB-1:0]         report;
    logic                  hit_here;
    seghist_pkg::token_t   token_reg;
    seghist_pkg::token_t   token_next;

    assign hit_here  = token_in.valid && token_in.hit &&
                       (token_in.block == seghist_pkg::SLOT_BITS'(INDEX));
    // Saturate at all ones
    assign count_inc = (hit_here && (count_reg != '1)) ?
                       count_reg + COUNT_BITS'(1) : count_reg;

    generate
        if (COUNT_BITS > OB) begin : g_clamp
            assign report = (|count_inc[COUNT_BITS-1:OB]) ? '1 : count_inc[OB-1:0];
        end else begin : g_extend
            assign report = OB'(count_inc);
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        token_next = token_in;
        if (token_in.valid)
        begin
            count_next = token_in.frame_end ? '0 : count_inc;
            if (token_in.frame_end)
            begin
                token_next.counts[INDEX] = report;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            token_reg <= '0;
        end
        else if (advance)
        begin
            count_reg <= count_next;
            token_reg <= token_next;
        end
    end

    assign token_out = token_reg;

endmodule

>>> src/segmentation_pixel_histogram_core.sv
// Top level: config registers, decode stage, row of block counter cells, result register.
// Pixels are accepted one per clock unless in_stall is high. Each pixel request is decoded
// in one registered stage and then walks a row of BLOCKS counter cells, one cell per clock
// while the row advances; the cell that owns the pixel's block bumps its saturating counter
// as the request passes. A frame_end request collects each cell's count (and clears it) on
// its way, and at the end of the row the frame's result is loaded into the result register.
// The input stalls only while a finished result reaches the end of the row and the result
// register is still held by a stalled consumer. Write configuration only while the block is idle.
module segmentation_pixel_histogram_core #(
    parameter int MAP_ENTRIES = 16,
    parameter int BLOCKS      = 7,
    parameter int COUNT_BITS  = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [seghist_pkg::MAP_BITS-1:0]     cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [7:0]                           red,
    input  logic [7:0]                           green,
    input  logic [7:0]                           blue,
    input  logic                                 frame_end,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [15:0]                          count_block0,
    output logic [15:0]                          count_block1,
    output logic [15:0]                          count_block2,
    output logic [15:0]                          count_block3,
    output logic [15:0]                          count_block4,
    output logic [15:0]                          count_block5,
    output logic [15:0]                          count_block6
);

    logic [seghist_pkg::MAP_BITS-1:0]     map_reg;
    logic [seghist_pkg::ENTRIES_BITS-1:0] entries_reg;

    seghist_pkg::token_t decoded;
    seghist_pkg::token_t head_reg;
    seghist_pkg::token_t chain [BLOCKS+1];
    seghist_pkg::token_t tail;

    logic                  advance;
    logic                  tail_result;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    seghist_pkg::counts_t  out_counts_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg     <= seghist_pkg::MAP_RESET;
            entries_reg <= seghist_pkg::ENTRIES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                seghist_pkg::REG_MAP:     map_reg     <= cfg_data;
                seghist_pkg::REG_ENTRIES: entries_reg <= cfg_data[seghist_pkg::ENTRIES_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign tail        = chain[BLOCKS];
    assign tail_result = tail.valid && tail.frame_end;
    // Hold the whole row only when a result cannot move into the output register
    assign advance     = !(tail_result && out_valid_reg && out_stall);
    assign in_stall    = !advance;

    seghist_decode #(
        .MAP_ENTRIES (MAP_ENTRIES),
        .BLOCKS      (BLOCKS)
    ) u_decode (
        .valid             (in_valid),
        .red               (red),
        .green             (green),
        .blue              (blue),
        .frame_end         (frame_end),
        .segment_block_map (map_reg),
        .segment_entries   (entries_reg),
        .token             (decoded)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
        end
        else if (advance)
        begin
            head_reg <= decoded;
        end
    end

    assign chain[0] = head_reg;

    generate
        for (genvar k = 0; k < BLOCKS; k++) begin : g_cell
            seghist_cell #(
                .INDEX      (k),
                .COUNT_BITS (COUNT_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .token_in  (chain[k]),
                .token_out (chain[k+1])
            );
        end
    endgenerate

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (tail_result && advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail_result && advance)
        begin
            out_counts_reg <= tail.counts;
        end
    end

    assign out_valid    = out_valid_reg;
    assign count_block0 = out_counts_reg[0];
    assign count_block1 = out_counts_reg[1];
    assign count_block2 = out_counts_reg[2];
    assign count_block3 = out_counts_reg[3];
    assign count_block4 = out_counts_reg[4];
    assign count_block5 = out_counts_reg[5];
    assign count_block6 = out_counts_reg[6];

endmodule
